// ===== sv/nth_prime_by_trial_division_core_macros.svh =====
// assertion macros used by the nth-prime core top level
// no dependencies; pulled in with include by the core top level, the only file that asserts
`ifndef NTH_PRIME_BY_TRIAL_DIVISION_CORE_MACROS_SVH
`define NTH_PRIME_BY_TRIAL_DIVISION_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define NTP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NTP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ntp_pkg.sv =====
// types, constants and the microcode rom of the nth-prime core
// no dependencies
`default_nettype none

package ntp_pkg;

    localparam int POSITION_W = 11;
    localparam int PRIME_W    = 13;
    // an 11-bit position never reaches a prime of 2^15
    localparam int CAND_W     = 15;
    localparam int DIV_W      = 8;
    localparam int SQ_W       = 16;
    localparam int PC_W       = 5;

    localparam logic [DIV_W-1:0]   FIRST_DIVISOR = DIV_W'(3);
    localparam logic [SQ_W-1:0]    FIRST_SQUARE  = SQ_W'(9);
    localparam logic [PRIME_W-1:0] FIRST_PRIME   = PRIME_W'(2);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_NEXT_CAND,
        OP_SQ_START,
        OP_DIV_INC,
        OP_FOUND_INC,
        OP_EMIT_CAND,
        OP_EMIT_ERR,
        OP_EMIT_TWO
    } dp_op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_BAD,
        C_ONE,
        C_FOUND_GE,
        C_SQ_GT,
        C_REM_BUSY,
        C_REM_ZERO,
        C_OUT_FULL
    } cond_t;

    typedef logic [PC_W-1:0] pc_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
        cond_t  cond;
        pc_t    target;
    } uword_t;

    typedef struct packed {
        logic   accept;
        dp_op_t op;
    } ntp_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic bad;
        logic one;
        logic found_ge;
        logic sq_gt;
        logic rem_busy;
        logic rem_zero;
        logic out_full;
    } ntp_status_t;

    localparam pc_t S_FETCH     = PC_W'(0);
    localparam pc_t S_INIT      = PC_W'(1);
    localparam pc_t S_CHK_ONE   = PC_W'(2);
    localparam pc_t S_LOOP      = PC_W'(3);
    localparam pc_t S_NEXT      = PC_W'(4);
    localparam pc_t S_TEST      = PC_W'(5);
    localparam pc_t S_TRY       = PC_W'(6);
    localparam pc_t S_WAIT_REM  = PC_W'(7);
    localparam pc_t S_CHK_REM   = PC_W'(8);
    localparam pc_t S_BACK      = PC_W'(9);
    localparam pc_t S_PRIME     = PC_W'(10);
    localparam pc_t S_DONE_WAIT = PC_W'(11);
    localparam pc_t S_DONE_EMIT = PC_W'(12);
    localparam pc_t S_ERR_WAIT  = PC_W'(13);
    localparam pc_t S_ERR_EMIT  = PC_W'(14);
    localparam pc_t S_TWO_WAIT  = PC_W'(15);
    localparam pc_t S_TWO_EMIT  = PC_W'(16);

    function automatic uword_t ntp_ucode(input pc_t pc);
        uword_t w;
        case (pc)
            S_FETCH:     w = '{1'b1, OP_LOAD,      C_NO_INPUT, S_FETCH};
            S_INIT:      w = '{1'b0, OP_INIT,      C_BAD,      S_ERR_WAIT};
            S_CHK_ONE:   w = '{1'b0, OP_NONE,      C_ONE,      S_TWO_WAIT};
            S_LOOP:      w = '{1'b0, OP_NONE,      C_FOUND_GE, S_DONE_WAIT};
            S_NEXT:      w = '{1'b0, OP_NEXT_CAND, C_NEVER,    S_FETCH};
            S_TEST:      w = '{1'b0, OP_NONE,      C_SQ_GT,    S_PRIME};
            S_TRY:       w = '{1'b0, OP_SQ_START,  C_NEVER,    S_FETCH};
            S_WAIT_REM:  w = '{1'b0, OP_NONE,      C_REM_BUSY, S_WAIT_REM};
            S_CHK_REM:   w = '{1'b0, OP_DIV_INC,   C_REM_ZERO, S_LOOP};
            S_BACK:      w = '{1'b0, OP_NONE,      C_ALWAYS,   S_TEST};
            S_PRIME:     w = '{1'b0, OP_FOUND_INC, C_ALWAYS,   S_LOOP};
            S_DONE_WAIT: w = '{1'b0, OP_NONE,      C_OUT_FULL, S_DONE_WAIT};
            S_DONE_EMIT: w = '{1'b0, OP_EMIT_CAND, C_ALWAYS,   S_FETCH};
            S_ERR_WAIT:  w = '{1'b0, OP_NONE,      C_OUT_FULL, S_ERR_WAIT};
            S_ERR_EMIT:  w = '{1'b0, OP_EMIT_ERR,  C_ALWAYS,   S_FETCH};
            S_TWO_WAIT:  w = '{1'b0, OP_NONE,      C_OUT_FULL, S_TWO_WAIT};
            S_TWO_EMIT:  w = '{1'b0, OP_EMIT_TWO,  C_ALWAYS,   S_FETCH};
            default:     w = '{1'b0, OP_NONE,      C_ALWAYS,   S_FETCH};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ntp_rem.sv =====
// bit-serial remainder unit: candidate mod divisor, one quotient bit per cycle
// depends on ntp_pkg
`default_nettype none

module ntp_rem
    import ntp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [CAND_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    output logic                   busy,
    output logic                   rem_zero
);

    localparam int CNT_W = $clog2(CAND_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CAND_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    assign trial = {rem_reg, dvd_reg[CAND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(CAND_W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[CAND_W-2:0], 1'b0};
            // restoring step: keep the difference when it did not go negative
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIV_W-1:0];
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

`default_nettype wire

// ===== sv/ntp_dp.sv =====
// datapath of the nth-prime core: position, count, candidate, divisor, square, output register
// depends on ntp_pkg and ntp_rem
`default_nettype none

module ntp_dp
    import ntp_pkg::*;
#(
    parameter int MAX_POSITION = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ntp_ctrl_t             ctrl,
    input  wire logic                  s_valid,
    input  wire logic [POSITION_W-1:0] s_position,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic [PRIME_W-1:0]         m_prime_value,
    output logic                       m_domain_error,
    output ntp_status_t                status
);

    localparam int MAX_W = $clog2(MAX_POSITION + 1);
    localparam int CMP_W = (MAX_W > POSITION_W) ? MAX_W : POSITION_W;

    logic [POSITION_W-1:0] pos_reg, pos_next;
    logic [POSITION_W-1:0] found_reg, found_next;
    logic [CAND_W-1:0]     cand_reg, cand_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PRIME_W-1:0]    m_prime_reg, m_prime_next;
    logic                  m_err_reg, m_err_next;
    logic                  rem_start;
    logic                  rem_busy;
    logic                  rem_zero;

    assign rem_start = (ctrl.op == OP_SQ_START);

    ntp_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .busy     (rem_busy),
        .rem_zero (rem_zero)
    );

    always_comb begin
        pos_next     = pos_reg;
        found_next   = found_reg;
        cand_next    = cand_reg;
        div_next     = div_reg;
        sq_next      = sq_reg;
        m_prime_next = m_prime_reg;
        m_err_next   = m_err_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (ctrl.op)
            OP_LOAD: begin
                if (s_valid && ctrl.accept) begin
                    pos_next = s_position;
                end
            end
            OP_INIT: begin
                found_next = POSITION_W'(1);
                cand_next  = CAND_W'(1);
            end
            OP_NEXT_CAND: begin
                cand_next = cand_reg + CAND_W'(2);
                div_next  = FIRST_DIVISOR;
                sq_next   = FIRST_SQUARE;
            end
            OP_SQ_START: begin
                sq_next = SQ_W'(div_reg) * SQ_W'(div_reg);
            end
            OP_DIV_INC: begin
                div_next = div_reg + DIV_W'(2);
            end
            OP_FOUND_INC: begin
                found_next = found_reg + POSITION_W'(1);
            end
            OP_EMIT_CAND: begin
                m_prime_next = cand_reg[PRIME_W-1:0];
                m_err_next   = 1'b0;
                m_valid_next = 1'b1;
            end
            OP_EMIT_ERR: begin
                m_prime_next = '0;
                m_err_next   = 1'b1;
                m_valid_next = 1'b1;
            end
            OP_EMIT_TWO: begin
                m_prime_next = FIRST_PRIME;
                m_err_next   = 1'b0;
                m_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        cand_reg    <= cand_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        m_prime_reg <= m_prime_next;
        m_err_reg   <= m_err_next;
    end

    always_comb begin
        status.in_valid = s_valid;
        status.bad      = (pos_reg == '0) || (CMP_W'(pos_reg) > CMP_W'(MAX_POSITION));
        status.one      = (pos_reg == POSITION_W'(1));
        status.found_ge = (found_reg >= pos_reg);
        status.sq_gt    = (sq_reg > SQ_W'(cand_reg));
        status.rem_busy = rem_busy;
        status.rem_zero = rem_zero;
        status.out_full = m_valid_reg && !m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_prime_value  = m_prime_reg;
    assign m_domain_error = m_err_reg;

endmodule

`default_nettype wire

// ===== sv/ntp_seq.sv =====
// microcode sequencer: step counter, rom lookup and conditional jump
// depends on ntp_pkg
`default_nettype none

module ntp_seq
    import ntp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ntp_status_t status,
    output ntp_ctrl_t        ctrl
);

    pc_t    pc_reg, pc_next;
    uword_t word;
    logic   taken;

    assign word = ntp_ucode(pc_reg);

    always_comb begin
        case (word.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_NO_INPUT: taken = !status.in_valid;
            C_BAD:      taken = status.bad;
            C_ONE:      taken = status.one;
            C_FOUND_GE: taken = status.found_ge;
            C_SQ_GT:    taken = status.sq_gt;
            C_REM_BUSY: taken = status.rem_busy;
            C_REM_ZERO: taken = status.rem_zero;
            C_OUT_FULL: taken = status.out_full;
            default:    taken = 1'b1;
        endcase
    end

    assign pc_next = taken ? word.target : pc_reg + PC_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.accept = word.accept;
    assign ctrl.op     = word.op;

endmodule

`default_nettype wire

// ===== sv/nth_prime_by_trial_division_core.sv =====
// nth prime by trial division; a microcoded sequencer drives a single bit-serial remainder unit
// position 0 or above MAX_POSITION yields a domain error and position 1 yields two; for any other
// position, odd candidates are tried in turn against odd trial divisors on the remainder unit
// throughput: one beat at a time; the next beat is taken the cycle after a result is loaded
// into the output register, which then waits for m_ready on its own
// reset: aresetn synchronous, active low; clears the step counter, output valid and remainder busy
`default_nettype none

`include "nth_prime_by_trial_division_core_macros.svh"

module nth_prime_by_trial_division_core
    import ntp_pkg::*;
#(
    parameter int MAX_POSITION = 1024
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [POSITION_W-1:0] s_position,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PRIME_W-1:0]         m_prime_value,
    output logic                       m_domain_error
);

    ntp_ctrl_t   ctrl;
    ntp_status_t status;

    ntp_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    ntp_dp #(
        .MAX_POSITION (MAX_POSITION)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .s_valid        (s_valid),
        .s_position     (s_position),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_prime_value  (m_prime_value),
        .m_domain_error (m_domain_error),
        .status         (status)
    );

    assign s_ready = ctrl.accept;

    `NTP_ASSERT_NOW(a_err_zero, aclk, aresetn, m_valid && m_domain_error,
        m_prime_value == '0, "domain error beat carries a nonzero prime")

    `NTP_ASSERT_NOW(a_prime_odd, aclk, aresetn, m_valid && !m_domain_error,
        m_prime_value[0] || (m_prime_value == FIRST_PRIME), "even prime other than two")

    `NTP_ASSERT_NEXT(a_one_beat, aclk, aresetn, s_valid && s_ready,
        !s_ready, "second beat taken before the first is worked off")

endmodule

`default_nettype wire

// ===== verif/nth_prime_by_trial_division_core_tb.sv =====
// self-checking testbench for nth_prime_by_trial_division_core: offers positions, predicts each
// prime by trial division in a small checker class and compares every returned beat in order
// depends on ntp_pkg and nth_prime_by_trial_division_core
module nth_prime_by_trial_division_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ntp_pkg::*;

    localparam int MAX_POS        = 1024;
    localparam int WATCHDOG_LIMIT = 5_000_000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 30;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic [PRIME_W-1:0]    prime_value;
        logic                  domain_error;
    } prime_answer_t;

    class prime_checker;
        int unsigned   max_position;
        prime_answer_t awaited[$];
        int unsigned   mismatches;
        int unsigned   checked;
        int unsigned   domain_hits;

        function new(int unsigned max_pos);
            max_position = max_pos;
            mismatches   = 0;
            checked      = 0;
            domain_hits  = 0;
        endfunction

        // divisor square is taken before the remainder test, so the loop runs one divisor past
        static function bit odd_is_prime(int unsigned cand);
            int unsigned divisor;
            int unsigned square;
            divisor = 3;
            square  = 9;
            while (square <= cand) begin
                square = divisor * divisor;
                if (cand % divisor == 0)
                    return 1'b0;
                divisor += 2;
            end
            return 1'b1;
        endfunction

        function logic [PRIME_W-1:0] prime_at(int unsigned pos);
            int unsigned found;
            int unsigned cand;
            found = 1;
            cand  = 1;
            if (pos == 1)
                return FIRST_PRIME;
            while (found < pos) begin
                cand += 2;
                if (odd_is_prime(cand))
                    found++;
            end
            return PRIME_W'(cand);
        endfunction

        function void note_position(logic [POSITION_W-1:0] pos);
            prime_answer_t answer;
            answer.position = pos;
            if (pos == 0 || pos > max_position) begin
                answer.prime_value  = '0;
                answer.domain_error = 1'b1;
            end else begin
                answer.prime_value  = prime_at(pos);
                answer.domain_error = 1'b0;
            end
            awaited.push_back(answer);
        endfunction

        function void check_prime(logic [PRIME_W-1:0] value, logic err);
            prime_answer_t answer;
            checked++;
            if (err === 1'b1)
                domain_hits++;
            if (awaited.size() == 0) begin
                $display("%0t: result with nothing pending: prime_value %0d domain_error %0b",
                         $time, value, err);
                mismatches++;
                return;
            end
            answer = awaited.pop_front();
            if (value !== answer.prime_value) begin
                $display("%0t: position %0d prime_value expected %0d actual %0d",
                         $time, answer.position, answer.prime_value, value);
                mismatches++;
            end
            if (err !== answer.domain_error) begin
                $display("%0t: position %0d domain_error expected %0b actual %0b",
                         $time, answer.position, answer.domain_error, err);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  s_valid        = 1'b0;
    logic [POSITION_W-1:0] s_position     = '0;
    logic                  m_ready        = 1'b0;
    wire logic             s_ready;
    wire logic             m_valid;
    wire logic [PRIME_W-1:0] m_prime_value;
    wire logic             m_domain_error;

    int          send_idle_pct  = 29;
    int          recv_idle_pct  = 45;
    int          recv_hold_left = 0;
    int unsigned positions_sent = 0;

    prime_checker primes = new(MAX_POS);

    nth_prime_by_trial_division_core #(
        .MAX_POSITION(MAX_POS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_value (m_prime_value),
        .m_domain_error(m_domain_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // valid stays up between back-to-back beats, it only drops on a gap
    task automatic send_position(input logic [POSITION_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_position <= pos;
        do @(posedge aclk); while (s_ready !== 1'b1);
        primes.note_position(pos);
        positions_sent++;
    endtask

    task automatic wait_all_answered();
        s_valid <= 1'b0;
        do @(posedge aclk); while (primes.pending() != 0);
    endtask

    // mostly short searches; a few mid-size ones and out-of-range positions
    function automatic logic [POSITION_W-1:0] random_position();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 12)
            return POSITION_W'($urandom_range(2 ** POSITION_W - 1, MAX_POS + 1));
        if (pick < 15)
            return POSITION_W'($urandom_range(200, 61));
        return POSITION_W'($urandom_range(60, 1));
    endfunction

    initial begin
        // first primes, squares of primes crossed on the way, range edges, all-ones
        int unsigned directed[14] = '{0, 1, 2, 3, 4, 5, 10, 16, 31, 100, 1024, 1025, 1536, 2047};
        int unsigned burst[6]     = '{1, 2, 3, 0, 6, 2};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_position(POSITION_W'(directed[i]));

        // output held off so the core fills up and drops s_ready
        recv_hold_left = LONG_HOLD;
        foreach (burst[i])
            send_position(POSITION_W'(burst[i]));
        wait_all_answered();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_position(random_position());
        end

        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d positions across three idle mixes and a %0d-cycle output stall",
                 positions_sent, LONG_HOLD);
        $display("checked %0d results, %0d of them out of domain, %0d mismatches",
                 primes.checked, primes.domain_hits, primes.mismatches);
        if (primes.mismatches == 0 && primes.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                primes.check_prime(m_prime_value, m_domain_error);
            if (recv_hold_left > 0) begin
                m_ready <= 1'b0;
                recv_hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (aresetn && ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== nth_prime_by_trial_division_core.f =====
+incdir+sv
sv/ntp_pkg.sv
sv/ntp_rem.sv
sv/ntp_dp.sv
sv/ntp_seq.sv
sv/nth_prime_by_trial_division_core.sv
verif/nth_prime_by_trial_division_core_tb.sv
